// ===== rtl/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

    // Console geometry
    localparam int TEXT_COLUMNS = 28;
    localparam int TEXT_ROWS    = 8;
    localparam int SCREEN_WIDTH = 240;

    localparam int COL_W = 5;
    localparam int ROW_W = 3;

    localparam int CELL_W      = 8;
    localparam int CELL_H      = 16;
    localparam int MARK_X0     = 224;
    localparam int MARK_X1     = 239;
    localparam int MARK_INSET0 = 4;
    localparam int MARK_INSET1 = 11;

    // Operation queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    typedef enum logic [1:0] {
        REQ_FORMAT  = 2'd0,
        REQ_LITERAL = 2'd1,
        REQ_RESET   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_GLYPH = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STEP_ROW   = 2'd0,
        STEP_ERASE = 2'd1,
        STEP_MARK  = 2'd2,
        STEP_GLYPH = 2'd3
    } t_step;

    // One classified operation for the back end
    typedef struct packed {
        logic             clr;   // clear whole screen
        logic             prep;  // row must be prepared before the glyph
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       code;
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/tccs_front.sv =====
`default_nettype none

module tccs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_q_full,
    output tccs_pkg::t_op      o_op,
    output logic               o_op_valid
);

    logic [tccs_pkg::COL_W-1:0] r_col, n_col;
    logic [tccs_pkg::ROW_W-1:0] r_row, n_row;
    logic                       r_marker, n_marker;

    logic                       accept;
    logic                       is_char;
    logic [tccs_pkg::ROW_W-1:0] row_inc;
    logic [tccs_pkg::COL_W-1:0] col_inc;

    assign accept  = i_push && !i_q_full;
    assign row_inc = (r_row == tccs_pkg::ROW_W'(tccs_pkg::TEXT_ROWS - 1))
                   ? '0 : r_row + tccs_pkg::ROW_W'(1);
    assign col_inc = r_col + tccs_pkg::COL_W'(1);

    assign is_char = (i_req_type == tccs_pkg::REQ_LITERAL)
                  || ((i_req_type == tccs_pkg::REQ_FORMAT)
                      && (i_char_code != tccs_pkg::CHAR_CR)
                      && (i_char_code != tccs_pkg::CHAR_LF));

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_marker   = r_marker;
        o_op_valid = 1'b0;
        o_op.clr   = 1'b0;
        o_op.prep  = !r_marker;
        o_op.row   = r_row;
        o_op.col   = r_col;
        o_op.code  = i_char_code;
        if (accept) begin
            if (i_req_type == tccs_pkg::REQ_RESET) begin
                o_op_valid = 1'b1;
                o_op.clr   = 1'b1;
                n_col      = '0;
                n_row      = '0;
                n_marker   = 1'b0;
            end else if (is_char) begin
                o_op_valid = 1'b1;
                n_marker   = 1'b1;
                n_col      = col_inc;
                // wrap to the next row
                if (col_inc == tccs_pkg::COL_W'(tccs_pkg::TEXT_COLUMNS)) begin
                    n_col    = '0;
                    n_row    = row_inc;
                    n_marker = 1'b0;
                end
            end else if (i_req_type == tccs_pkg::REQ_FORMAT) begin
                if (i_char_code == tccs_pkg::CHAR_CR) begin
                    n_col = '0;
                end else begin
                    n_row    = row_inc;
                    n_marker = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_marker <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_marker <= n_marker;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tccs_queue.sv =====
`default_nettype none

module tccs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tccs_pkg::t_op i_op,
    output logic               o_full,
    input  wire logic          i_pop,
    output tccs_pkg::t_op      o_head,
    output logic               o_empty
);

    tccs_pkg::t_op               r_ent [tccs_pkg::Q_DEPTH];
    tccs_pkg::t_op               n_ent [tccs_pkg::Q_DEPTH];
    logic [tccs_pkg::Q_CW-1:0]   r_cnt, n_cnt;
    logic [tccs_pkg::Q_CW-1:0]   wr_pos;
    logic                        do_pop;

    assign o_full  = (r_cnt == tccs_pkg::Q_CW'(tccs_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_ent[0];
    assign do_pop  = i_pop && !o_empty;
    assign wr_pos  = do_pop ? r_cnt - tccs_pkg::Q_CW'(1) : r_cnt;

    always_comb begin
        for (int i = 0; i < tccs_pkg::Q_DEPTH - 1; i++) begin
            n_ent[i] = do_pop ? r_ent[i + 1] : r_ent[i];
        end
        n_ent[tccs_pkg::Q_DEPTH - 1] = r_ent[tccs_pkg::Q_DEPTH - 1];
        if (i_push) begin
            n_ent[wr_pos[tccs_pkg::Q_AW-1:0]] = i_op;
        end
        n_cnt = r_cnt + tccs_pkg::Q_CW'(i_push) - tccs_pkg::Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tccs_pkg::Q_DEPTH; i++) begin
            r_ent[i] <= n_ent[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tccs_back.sv =====
`default_nettype none

module tccs_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tccs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data,
    input  wire tccs_pkg::t_op                  i_head,
    input  wire logic                           i_q_empty,
    output logic                                o_q_pop,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output logic [1:0]                          o_cmd_kind,
    output logic [7:0]                          o_x_start,
    output logic [7:0]                          o_y_start,
    output logic [7:0]                          o_x_end,
    output logic [7:0]                          o_y_end,
    output logic [15:0]                         o_draw_color,
    output logic [7:0]                          o_glyph_code,
    output logic                                o_last
);

    logic [15:0] r_text_color;
    logic [15:0] r_bg_color;

    tccs_pkg::t_step r_step, n_step, cur_step;

    logic        r_out_valid;
    logic        can_load;
    logic        fire;
    logic        final_cmd;
    logic [7:0]  y_row;
    logic [7:0]  y_prev;
    logic [7:0]  x_col;
    logic [tccs_pkg::ROW_W-1:0] prev_row;

    tccs_pkg::t_cmd c_kind;
    logic [7:0]     c_xs, c_ys, c_xe, c_ye, c_glyph;
    logic [15:0]    c_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= 16'hFFFF;
            r_bg_color   <= 16'h0000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tccs_pkg::CFG_TEXT_COLOR) begin
                r_text_color <= i_cfg_data;
            end
            if (i_cfg_index == tccs_pkg::CFG_BACKGROUND_COLOR) begin
                r_bg_color <= i_cfg_data;
            end
        end
    end

    assign can_load = !r_out_valid || i_pop;
    assign fire     = !i_q_empty && can_load;
    assign o_q_pop  = fire && final_cmd;

    // skip row preparation when the row is already set up
    assign cur_step  = (i_head.prep || i_head.clr) ? r_step : tccs_pkg::STEP_GLYPH;
    assign final_cmd = i_head.clr || (cur_step == tccs_pkg::STEP_GLYPH);

    assign prev_row = (i_head.row == '0) ? tccs_pkg::ROW_W'(tccs_pkg::TEXT_ROWS - 1)
                                         : i_head.row - tccs_pkg::ROW_W'(1);
    assign y_row    = 8'(32'(i_head.row) * tccs_pkg::CELL_H);
    assign y_prev   = 8'(32'(prev_row) * tccs_pkg::CELL_H);
    assign x_col    = 8'(32'(i_head.col) * tccs_pkg::CELL_W);

    // next step
    always_comb begin
        n_step = r_step;
        if (fire) begin
            if (final_cmd) begin
                n_step = tccs_pkg::STEP_ROW;
            end else begin
                unique case (cur_step)
                    tccs_pkg::STEP_ROW:   n_step = tccs_pkg::STEP_ERASE;
                    tccs_pkg::STEP_ERASE: n_step = tccs_pkg::STEP_MARK;
                    tccs_pkg::STEP_MARK:  n_step = tccs_pkg::STEP_GLYPH;
                    default:              n_step = tccs_pkg::STEP_ROW;
                endcase
            end
        end
    end

    // command for the current step
    always_comb begin
        c_kind  = tccs_pkg::CMD_FILL;
        c_xs    = '0;
        c_ys    = '0;
        c_xe    = '0;
        c_ye    = '0;
        c_color = r_bg_color;
        c_glyph = '0;
        if (i_head.clr) begin
            c_kind = tccs_pkg::CMD_CLEAR;
        end else begin
            unique case (cur_step)
                tccs_pkg::STEP_ROW: begin
                    c_ys = y_row;
                    c_xe = 8'(tccs_pkg::SCREEN_WIDTH - 1);
                    c_ye = y_row + 8'(tccs_pkg::CELL_H);
                end
                tccs_pkg::STEP_ERASE: begin
                    c_xs = 8'(tccs_pkg::MARK_X0);
                    c_ys = y_prev;
                    c_xe = 8'(tccs_pkg::MARK_X1);
                    c_ye = y_prev + 8'(tccs_pkg::CELL_H);
                end
                tccs_pkg::STEP_MARK: begin
                    c_xs    = 8'(tccs_pkg::MARK_X0 + tccs_pkg::MARK_INSET0);
                    c_ys    = y_row + 8'(tccs_pkg::MARK_INSET0);
                    c_xe    = 8'(tccs_pkg::MARK_X0 + tccs_pkg::MARK_INSET1);
                    c_ye    = y_row + 8'(tccs_pkg::MARK_INSET1);
                    c_color = r_text_color;
                end
                tccs_pkg::STEP_GLYPH: begin
                    c_kind  = tccs_pkg::CMD_GLYPH;
                    c_xs    = x_col;
                    c_ys    = y_row;
                    c_color = r_text_color;
                    c_glyph = i_head.code;
                end
                default: begin
                    c_kind = tccs_pkg::CMD_FILL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= tccs_pkg::STEP_ROW;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (can_load) begin
                r_out_valid <= fire;
            end
        end
    end

    // result register: hold while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_cmd_kind   <= c_kind;
            o_x_start    <= c_xs;
            o_y_start    <= c_ys;
            o_x_end      <= c_xe;
            o_y_end      <= c_ye;
            o_draw_color <= c_color;
            o_glyph_code <= c_glyph;
            o_last       <= final_cmd;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_sequencer.sv =====
`default_nettype none

// Text console cursor sequencer: turns a character stream into draw commands for a
// 28 x 8 console of 8x16 cells. The front end takes one transaction per cycle while its
// four-entry operation queue has room; carriage return and line feed update the cursor
// there and produce no command, and unused request types are ignored. The back end loads
// one command per cycle into its result register unless the consumer stalls: a character
// that opens a new row gives four commands (row clear, previous marker erase, marker draw,
// glyph), other characters and console resets give one. Sustained throughput is set by the
// back-end command rate. Color registers must only be written while the block is idle.
module text_console_cursor_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tccs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [7:0]                     i_char_code,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [1:0]                          o_cmd_kind,
    output logic [7:0]                          o_x_start,
    output logic [7:0]                          o_y_start,
    output logic [7:0]                          o_x_end,
    output logic [7:0]                          o_y_end,
    output logic [15:0]                         o_draw_color,
    output logic [7:0]                          o_glyph_code,
    output logic                                o_last
);

    tccs_pkg::t_op op_in;
    tccs_pkg::t_op op_head;
    logic          op_valid;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign full = q_full;

    tccs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req_type  (i_req_type),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_op        (op_in),
        .o_op_valid  (op_valid)
    );

    tccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_op    (op_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (op_head),
        .o_empty (q_empty)
    );

    tccs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head       (op_head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_cmd_kind   (o_cmd_kind),
        .o_x_start    (o_x_start),
        .o_y_start    (o_y_start),
        .o_x_end      (o_x_end),
        .o_y_end      (o_y_end),
        .o_draw_color (o_draw_color),
        .o_glyph_code (o_glyph_code),
        .o_last       (o_last)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(op_valid && q_full))
        else $error("operation queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("operation retired from empty queue");

    a_fill_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cmd_kind == tccs_pkg::CMD_FILL) |-> !o_last)
        else $error("fill command marked last");

    a_glyph_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_cmd_kind == tccs_pkg::CMD_GLYPH || o_cmd_kind == tccs_pkg::CMD_CLEAR))
        |-> o_last)
        else $error("final command not marked last");

endmodule

`default_nettype wire
